// ===== src/faru_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction ALU package
// Operation codes and the default operand width shared by the fraction ALU modules.
// ----------------------------------------------------------------------------
package faru_pkg;

   localparam int OperandWidth = 16;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

endpackage

// ===== src/fraction_alu_with_reduction_unit.sv =====
// ----------------------------------------------------------------------------
// Fraction ALU with reduction
// Adds, subtracts, multiplies or divides two signed fractions and reduces the
// result by the gcd of the magnitudes.
//
//   channel  dir  tdata fields (low bit first)
//   req_     in   kind, a_num, a_den, b_num, b_den
//   rsp_     out  raw_num, raw_den, low_num, low_den, status
//
// One beat takes an accept step, two (multiply, divide) or three (add,
// subtract) product steps on a shared multiplier, k Euclid steps on the
// shared divider, two final divisions on the same divider and an output
// step. A zero denominator skips gcd and division.
// Ready is low while a beat is in work; a held result waits in the output
// register until taken. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module fraction_alu_with_reduction_unit
   import faru_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidth
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // kind, a_num, a_den, b_num, b_den
   input  logic [((4 * OPERAND_WIDTH + 2 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // raw_num, raw_den, low_num, low_den, status
   output logic [((4 * (2 * OPERAND_WIDTH + 1) + 1 + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int OW = OPERAND_WIDTH;
   localparam int RW = 2 * OW + 1;
   localparam int PW = ((4 * RW + 1 + 7) / 8) * 8;

   typedef enum logic [3:0] {
      S_IDLE, S_P0, S_P1, S_P2, S_GCD, S_GWAIT, S_DN, S_DNW, S_DD, S_DDW, S_OUT
   } state_type;

   state_type     state_ff;
   op_type        kind_ff;
   logic signed [OW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [RW-1:0] p_ff;
   logic signed [RW-1:0] rn_ff, rd_ff, ln_ff, ld_ff;
   logic [RW-1:0] gx_ff, gy_ff;
   logic          zero_ff;
   logic          ovalid_ff;
   logic [PW-1:0] odata_ff;

   // shared multiplier
   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [2*OW-1:0] mul_p;
   logic signed [RW-1:0] sum_val;
   assign mul_p = mul_a * mul_b;
   assign sum_val = (kind_ff == OP_SUB) ? p_ff - RW'(mul_p) : p_ff + RW'(mul_p);

   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (state_ff)
         S_P0: begin
            mul_a = an_ff;
            mul_b = (kind_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         S_P1: begin
            mul_a = ad_ff;
            mul_b = (kind_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         S_P2: begin
            mul_a = ad_ff;
            mul_b = bn_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   // shared divider: gcd remainders and final quotients
   logic          div_start;
   logic [RW-1:0] div_a, div_b, div_q;
   logic          div_done;
   logic [RW-1:0] rem_val;
   logic [RW-1:0] mag_rn, mag_rd;

   assign mag_rn = rn_ff[RW-1] ? RW'(-rn_ff) : RW'(rn_ff);
   assign mag_rd = rd_ff[RW-1] ? RW'(-rd_ff) : RW'(rd_ff);

   always_comb begin
      div_start = 1'b0;
      div_a     = gx_ff;
      div_b     = gy_ff;
      case (state_ff)
         S_GCD: div_start = 1'b1;
         S_DN: begin
            div_start = 1'b1;
            div_a     = mag_rn;
            div_b     = gx_ff;
         end
         S_DD: begin
            div_start = 1'b1;
            div_a     = mag_rd;
            div_b     = gx_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   faru_divider #(.W(RW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (rem_val)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!ovalid_ff || rsp_tready)) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= op_type'(req_tdata[1:0]);
                  an_ff    <= req_tdata[2 +: OW];
                  ad_ff    <= req_tdata[2 + OW +: OW];
                  bn_ff    <= req_tdata[2 + 2 * OW +: OW];
                  bd_ff    <= req_tdata[2 + 3 * OW +: OW];
                  state_ff <= S_P0;
               end
            end
            S_P0: begin
               p_ff     <= RW'(mul_p);
               state_ff <= S_P1;
            end
            S_P1: begin
               rd_ff <= RW'(mul_p);
               gy_ff <= mul_p[2*OW-1] ? RW'(-RW'(mul_p)) : RW'(mul_p);
               if (kind_ff == OP_ADD || kind_ff == OP_SUB) begin
                  state_ff <= S_P2;
               end else begin
                  rn_ff    <= p_ff;
                  gx_ff    <= p_ff[RW-1] ? RW'(-p_ff) : RW'(p_ff);
                  zero_ff  <= (mul_p == '0);
                  state_ff <= (mul_p == '0) ? S_OUT : S_GCD;
               end
            end
            S_P2: begin
               rn_ff    <= sum_val;
               gx_ff    <= sum_val[RW-1] ? RW'(-sum_val) : RW'(sum_val);
               zero_ff  <= (rd_ff == '0);
               state_ff <= (rd_ff == '0) ? S_OUT : S_GCD;
            end
            S_GCD: begin
               // x and y hold the current Euclid pair
               state_ff <= S_GWAIT;
            end
            S_GWAIT: begin
               if (div_done) begin
                  if (rem_val == '0) begin
                     gx_ff    <= gy_ff;
                     state_ff <= S_DN;
                  end else begin
                     gx_ff    <= gy_ff;
                     gy_ff    <= rem_val;
                     state_ff <= S_GCD;
                  end
               end
            end
            S_DN: state_ff <= S_DNW;
            S_DNW: begin
               if (div_done) begin
                  ln_ff    <= rn_ff[RW-1] ? RW'(-div_q) : div_q;
                  state_ff <= S_DD;
               end
            end
            S_DD: state_ff <= S_DDW;
            S_DDW: begin
               if (div_done) begin
                  ld_ff    <= rd_ff[RW-1] ? RW'(-div_q) : div_q;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!ovalid_ff || rsp_tready) begin
                  odata_ff  <= PW'({zero_ff,
                                    zero_ff ? rd_ff : ld_ff,
                                    zero_ff ? rn_ff : ln_ff,
                                    rd_ff, rn_ff});
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   unused_check: assert property (@(posedge clock) disable iff (reset)
      (req_tready |-> state_ff == S_IDLE))
      else $error("ready outside idle");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a beat while busy");

   a_zero_passthru: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4*RW]) |-> rsp_tdata[RW +: RW] == '0)
      else $error("zero status with nonzero denominator");

endmodule

// ===== src/faru_divider.sv =====
// ----------------------------------------------------------------------------
// Fraction ALU restoring divider
// Unsigned radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module faru_divider
   import faru_pkg::*;
#(
   parameter int W = 2 * OperandWidth + 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== tb/fraction_alu_with_reduction_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fraction ALU with reduction testbench
// Drives operand beats with random gaps, predicts raw and reduced results in
// the bench, and compares each response beat field by field.
// ----------------------------------------------------------------------------
module fraction_alu_with_reduction_unit_tb;
   import faru_pkg::*;

   localparam int W = OperandWidth;
   localparam int RW = 2 * W + 1;
   localparam int REQ_BITS = ((4 * W + 2 + 7) / 8) * 8;
   localparam int RSP_BITS = ((4 * RW + 1 + 7) / 8) * 8;
   localparam int LONG_HOLD = 4000;

   // raw_num sits in the lowest bits, status in the highest
   typedef struct packed {
      logic          status;
      logic [RW-1:0] low_den;
      logic [RW-1:0] low_num;
      logic [RW-1:0] raw_den;
      logic [RW-1:0] raw_num;
   } fraction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   fraction_type expected_fractions[$];
   int mismatches = 0;
   int results_seen = 0;
   bit idle_on = 1'b1;
   bit long_stall = 1'b0;
   int long_count = 0;
   int hold_off = 0;

   fraction_alu_with_reduction_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_type reduce_fraction(op_type op, logic signed [W-1:0] an,
                                                    logic signed [W-1:0] ad,
                                                    logic signed [W-1:0] bn,
                                                    logic signed [W-1:0] bd);
      fraction_type f;
      longint rn, rd, ln, ld;
      longint unsigned g, mn, md;
      case (op)
         OP_ADD: begin rn = an * bd + ad * bn; rd = ad * bd; end
         OP_SUB: begin rn = an * bd - ad * bn; rd = ad * bd; end
         OP_MUL: begin rn = an * bn; rd = ad * bd; end
         default: begin rn = an * bd; rd = ad * bn; end
      endcase
      ln = rn;
      ld = rd;
      if (rd != 0) begin
         mn = (rn < 0) ? -rn : rn;
         md = (rd < 0) ? -rd : rd;
         g = gcd_of(mn, md);
         ln = (rn < 0) ? -longint'(mn / g) : longint'(mn / g);
         ld = (rd < 0) ? -longint'(md / g) : longint'(md / g);
      end
      f.raw_num = rn[RW-1:0];
      f.raw_den = rd[RW-1:0];
      f.low_num = ln[RW-1:0];
      f.low_den = ld[RW-1:0];
      f.status = (rd == 0);
      return f;
   endfunction

   // Drive one beat; queue its prediction when it is accepted.
   task automatic send_fraction(op_type op, logic [W-1:0] an, logic [W-1:0] ad,
                                logic [W-1:0] bn, logic [W-1:0] bd);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_BITS'({bd, bn, ad, an, op});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
      @(negedge clock);
   endtask

   function automatic logic [W-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(W-1){1'b0}}};
         1: return {1'b0, {(W-1){1'b1}}};
         2: return '0;
         3: return W'($urandom_range(0, 20)) - W'(10);
         default: return W'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall && long_count < LONG_HOLD) begin
         long_count <= long_count + 1;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         hold_off <= $urandom_range(1, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      fraction_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[4*RW:0];
         results_seen <= results_seen + 1;
         if (expected_fractions.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result beat %h", got);
         end else begin
            want = expected_fractions.pop_front();
            if (got !== want) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: raw %h/%h low %h/%h st %b, expected %h/%h %h/%h %b",
                           got.raw_num, got.raw_den, got.low_num, got.low_den, got.status,
                           want.raw_num, want.raw_den, want.low_num, want.low_den,
                           want.status);
            end
         end
      end
   end

   task automatic test_directed();
      logic [W-1:0] mx, mn;
      mx = {1'b0, {(W-1){1'b1}}};
      mn = {1'b1, {(W-1){1'b0}}};
      send_fraction(OP_ADD, W'(1), W'(2), W'(1), W'(3));
      send_fraction(OP_SUB, W'(1), W'(2), W'(1), W'(2));
      send_fraction(OP_MUL, W'(2), W'(3), W'(3), W'(4));
      send_fraction(OP_DIV, W'(2), W'(3), W'(4), W'(9));
      send_fraction(OP_ADD, W'(1), W'(0), W'(1), W'(5));
      send_fraction(OP_MUL, W'(3), W'(4), W'(5), W'(0));
      send_fraction(OP_DIV, W'(3), W'(4), W'(0), W'(5));
      send_fraction(OP_SUB, W'(0), W'(-7), W'(0), W'(3));
      send_fraction(OP_MUL, W'(0), W'(6), W'(5), W'(-7));
      send_fraction(OP_ADD, mn, mn, mn, mn);
      send_fraction(OP_SUB, mn, mx, mx, mn);
      send_fraction(OP_MUL, mn, W'(1), mn, W'(1));
      send_fraction(OP_DIV, mx, mn, mn, mx);
      send_fraction(OP_ADD, mx, mx, mx, mx);
      send_fraction(OP_SUB, mx, W'(1), mn, W'(1));
      send_fraction(OP_DIV, W'(-1), W'(-1), W'(-1), W'(-1));
      send_fraction(OP_ADD, '1, '1, '1, '1);
      send_fraction(OP_MUL, '0, '0, '0, '0);
   endtask

   task automatic test_random(int count);
      repeat (count)
         send_fraction(op_type'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                       pick_operand(), pick_operand());
   endtask

   // Hold the receiver off while beats keep coming so the input stalls.
   task automatic test_backpressure();
      long_stall = 1'b1;
      test_random(6);
      long_stall = 1'b0;
   endtask

   initial begin
      int guard;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400);
      test_backpressure();
      test_random(400);
      idle_on = 1'b0;
      test_random(80);
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_fractions.size() != 0 && guard < 2_000_000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_fractions.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/faru_pkg.sv
src/faru_divider.sv
src/fraction_alu_with_reduction_unit.sv
tb/fraction_alu_with_reduction_unit_tb.sv
